// ===== hdl/lfpid_pkg.sv =====
// Shared types and constants for the line-follow PID differential-drive core.
// No dependencies.
package lfpid_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BASE_SPEED = 3'd0,
        REG_TURN_LIMIT = 3'd1,
        REG_REFERENCE  = 3'd2,
        REG_GAIN_P     = 3'd3,
        REG_GAIN_I     = 3'd4,
        REG_GAIN_D     = 3'd5
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int POS_W   = 13;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // Reset values
    localparam logic [7:0]        BASE_SPEED_RST = 8'd30;
    localparam logic [7:0]        TURN_LIMIT_RST = 8'd80;
    localparam logic signed [8:0] REFERENCE_RST  = 9'sd0;
    localparam logic [15:0]       GAIN_P_RST     = 16'd256;
    localparam logic [15:0]       GAIN_I_RST     = 16'd0;
    localparam logic [15:0]       GAIN_D_RST     = 16'd0;

    // Position map: floor(pos * 510 / 5000) == (pos * MAP_MULT) >> MAP_SHIFT for pos <= 5000
    localparam logic [POS_W-1:0] POS_MAX    = 13'd5000;
    localparam logic [31:0]      MAP_MULT   = 32'd427820;
    localparam int               MAP_SHIFT  = 22;
    localparam logic signed [10:0] MAP_OFFSET = 11'sd255;

    localparam logic signed [16:0] SUM_MAX = 17'sd32767;
    localparam logic signed [16:0] SUM_MIN = -17'sd32768;

endpackage

// ===== hdl/line_follow_pid_differential_drive_core.sv =====
// Line-follow PID steering core: position map, PID, clamp, motor drive.
// Depends on lfpid_pkg.
// Six register stages lie between an input transfer and m_tvalid; the first loads on
// the transfer edge itself.
// Throughput: one item per cycle unless m_tready stalls the output; every stage is a
// single pass, the only loop (error sum and previous error) closes inside the error stage.
// Reset (aresetn low, synchronous): pipeline emptied, error state cleared,
// configuration registers back to their defaults.
module line_follow_pid_differential_drive_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [lfpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfpid_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfpid_pkg::S_DATA_W-1:0]    s_tdata,   // [12:0] line_position
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [8:0] correction, [9] left_forward, [17:10] left_pwm,
    // [18] right_forward, [26:19] right_pwm
    output logic [lfpid_pkg::M_DATA_W-1:0]    m_tdata
);

    // ---------------- configuration ----------------
    logic [7:0]        base_speed_reg;
    logic [7:0]        turn_limit_reg;
    logic signed [8:0] reference_reg;
    logic [15:0]       gain_p_reg;
    logic [15:0]       gain_i_reg;
    logic [15:0]       gain_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_speed_reg <= lfpid_pkg::BASE_SPEED_RST;
            turn_limit_reg <= lfpid_pkg::TURN_LIMIT_RST;
            reference_reg  <= lfpid_pkg::REFERENCE_RST;
            gain_p_reg     <= lfpid_pkg::GAIN_P_RST;
            gain_i_reg     <= lfpid_pkg::GAIN_I_RST;
            gain_d_reg     <= lfpid_pkg::GAIN_D_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lfpid_pkg::REG_BASE_SPEED: base_speed_reg <= cfg_wdata[7:0];
                lfpid_pkg::REG_TURN_LIMIT: turn_limit_reg <= cfg_wdata[7:0];
                lfpid_pkg::REG_REFERENCE:  reference_reg  <= $signed(cfg_wdata[8:0]);
                lfpid_pkg::REG_GAIN_P:     gain_p_reg     <= cfg_wdata;
                lfpid_pkg::REG_GAIN_I:     gain_i_reg     <= cfg_wdata;
                lfpid_pkg::REG_GAIN_D:     gain_d_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign s5_ready  = !s5_valid_reg  || out_ready;
    assign s4_ready  = !s4_valid_reg  || s5_ready;
    assign s3_ready  = !s3_valid_reg  || s4_ready;
    assign s2_ready  = !s2_valid_reg  || s3_ready;
    assign s1_ready  = !s1_valid_reg  || s2_ready;
    assign s_tready  = s1_ready;

    logic s1_load, s2_load, s3_load, s4_load, s5_load, out_load;
    assign s1_load  = s_tvalid     && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign s4_load  = s3_valid_reg && s4_ready;
    assign s5_load  = s4_valid_reg && s5_ready;
    assign out_load = s5_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready)  s1_valid_reg  <= s_tvalid;
            if (s2_ready)  s2_valid_reg  <= s1_valid_reg;
            if (s3_ready)  s3_valid_reg  <= s2_valid_reg;
            if (s4_ready)  s4_valid_reg  <= s3_valid_reg;
            if (s5_ready)  s5_valid_reg  <= s4_valid_reg;
            if (out_ready) out_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------- stage 1: capture position ----------------
    logic [lfpid_pkg::POS_W-1:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (s1_load) pos_reg <= s_tdata[lfpid_pkg::POS_W-1:0];
    end

    // ---------------- stage 2: map to 0..510 ----------------
    logic [lfpid_pkg::POS_W-1:0] pos_sat;
    logic [31:0]                 map_prod;
    logic [8:0]                  map_q_next;
    logic [8:0]                  map_q_reg;

    always_comb begin
        pos_sat    = (pos_reg > lfpid_pkg::POS_MAX) ? lfpid_pkg::POS_MAX : pos_reg;
        map_prod   = {19'd0, pos_sat} * lfpid_pkg::MAP_MULT;
        map_q_next = map_prod[lfpid_pkg::MAP_SHIFT+8:lfpid_pkg::MAP_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (s2_load) map_q_reg <= map_q_next;
    end

    // ---------------- stage 3: error, sum, difference ----------------
    logic signed [9:0]  prev_err_reg;
    logic signed [15:0] err_sum_reg;
    logic signed [10:0] mapped;
    logic signed [10:0] err_wide;
    logic signed [9:0]  err_next;
    logic signed [16:0] sum_wide;
    logic signed [15:0] sum_next;
    logic signed [10:0] diff_next;
    logic signed [9:0]  err_reg;
    logic signed [15:0] sum_reg;
    logic signed [10:0] diff_reg;

    always_comb begin
        mapped    = $signed({2'b00, map_q_reg}) - lfpid_pkg::MAP_OFFSET;
        err_wide  = mapped - {{2{reference_reg[8]}}, reference_reg};
        err_next  = err_wide[9:0];
        sum_wide  = {err_sum_reg[15], err_sum_reg} + {{7{err_next[9]}}, err_next};
        if (sum_wide > lfpid_pkg::SUM_MAX) begin
            sum_next = lfpid_pkg::SUM_MAX[15:0];
        end else if (sum_wide < lfpid_pkg::SUM_MIN) begin
            sum_next = lfpid_pkg::SUM_MIN[15:0];
        end else begin
            sum_next = sum_wide[15:0];
        end
        diff_next = {err_next[9], err_next} - {prev_err_reg[9], prev_err_reg};
    end

    // controller state advances once per item, as it enters this stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
        end else if (s3_load) begin
            prev_err_reg <= err_next;
            err_sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_load) begin
            err_reg  <= err_next;
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
        end
    end

    // ---------------- stage 4: gain products (Q8.8) ----------------
    logic signed [25:0] prod_p_next, prod_p_reg;
    logic signed [31:0] prod_i_next, prod_i_reg;
    logic signed [26:0] prod_d_next, prod_d_reg;
    logic signed [26:0] prod_p_full;
    logic signed [32:0] prod_i_full;
    logic signed [27:0] prod_d_full;

    always_comb begin
        prod_p_full = err_reg  * $signed({1'b0, gain_p_reg});
        prod_i_full = sum_reg  * $signed({1'b0, gain_i_reg});
        prod_d_full = diff_reg * $signed({1'b0, gain_d_reg});
        prod_p_next = prod_p_full[25:0];
        prod_i_next = prod_i_full[31:0];
        prod_d_next = prod_d_full[26:0];
    end

    always_ff @(posedge aclk) begin
        if (s4_load) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    // ---------------- stage 5: sum, floor shift, clamp ----------------
    logic signed [33:0] acc;
    logic signed [25:0] corr_full;
    logic signed [25:0] lim_pos;
    logic signed [25:0] lim_neg;
    logic signed [8:0]  corr_next, corr_reg;

    always_comb begin
        acc = {{8{prod_p_reg[25]}}, prod_p_reg}
            + {{2{prod_i_reg[31]}}, prod_i_reg}
            + {{7{prod_d_reg[26]}}, prod_d_reg};
        corr_full = acc[33:8];   // arithmetic shift: floor of acc / 256
        lim_pos   = $signed({18'd0, turn_limit_reg});
        lim_neg   = -lim_pos;
        if (corr_full > lim_pos) begin
            corr_next = lim_pos[8:0];
        end else if (corr_full < lim_neg) begin
            corr_next = lim_neg[8:0];
        end else begin
            corr_next = corr_full[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_load) corr_reg <= corr_next;
    end

    // ---------------- output stage: motor drive ----------------
    // speed range -255..510; forward only when strictly positive
    function automatic logic [8:0] motor_drive(input logic signed [9:0] speed);
        logic [9:0] mag;
        logic [7:0] pwm;
        mag = speed[9] ? 10'(-speed) : 10'(speed);
        pwm = (mag > 10'd255) ? 8'd255 : mag[7:0];
        return {(!speed[9] && (speed != 10'sd0)), pwm};
    endfunction

    logic signed [9:0] left_speed, right_speed;
    logic [8:0]        left_drv, right_drv;
    logic signed [8:0] out_corr_reg;
    logic              left_fwd_reg, right_fwd_reg;
    logic [7:0]        left_pwm_reg, right_pwm_reg;

    always_comb begin
        left_speed  = $signed({2'b00, base_speed_reg}) + {corr_reg[8], corr_reg};
        right_speed = $signed({2'b00, base_speed_reg}) - {corr_reg[8], corr_reg};
        left_drv    = motor_drive(left_speed);
        right_drv   = motor_drive(right_speed);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_corr_reg  <= corr_reg;
            left_fwd_reg  <= left_drv[8];
            left_pwm_reg  <= left_drv[7:0];
            right_fwd_reg <= right_drv[8];
            right_pwm_reg <= right_drv[7:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, right_pwm_reg, right_fwd_reg, left_pwm_reg, left_fwd_reg,
                       out_corr_reg};

    // ---------------- assertions ----------------
    // error state moves only when an item enters the error stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s3_load |=> $stable(err_sum_reg) && $stable(prev_err_reg))
        else $error("controller state changed without an item");

    // input side stalls only when every stage, output included, is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && s1_valid_reg && s5_valid_reg)
        else $error("input stalled with room in the pipeline");

    // a forward bit always comes with a nonzero magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!left_fwd_reg || left_pwm_reg != 8'd0)
                  && (!right_fwd_reg || right_pwm_reg != 8'd0))
        else $error("forward bit with zero pwm");

endmodule

// ===== verif/line_follow_pid_differential_drive_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the line-follow PID differential-drive core: directed table,
// then random register settings and positions against a cycle-free steering predictor.
// Depends on lfpid_pkg and line_follow_pid_differential_drive_core.
module line_follow_pid_differential_drive_core_tb;

    localparam int POSITION_SPAN  = 5000;
    localparam int MAPPED_RANGE   = 510;
    localparam int MAPPED_OFFSET  = 255;
    localparam int INTEG_HIGH     = 32767;
    localparam int INTEG_LOW      = -32768;
    localparam int PWM_FULL       = 255;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int MAX_GAP        = 18;

    // register indexes the core does not decode
    localparam logic [lfpid_pkg::CFG_INDEX_W-1:0] UNUSED_LO = 3'd6;
    localparam logic [lfpid_pkg::CFG_INDEX_W-1:0] UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] right_pwm;
        logic       right_fwd;
        logic [7:0] left_pwm;
        logic       left_fwd;
        logic [8:0] correction;
    } drive_cmd_t;

    typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_t;
    typedef enum int { SWEEP_FULL, SWEEP_HIGH, SWEEP_LOW, SWEEP_CENTER, SWEEP_RAW } sweep_t;

    typedef struct {
        row_kind_t                         kind;
        logic [lfpid_pkg::CFG_INDEX_W-1:0] idx;
        logic [lfpid_pkg::CFG_DATA_W-1:0]  value;
        logic [lfpid_pkg::POS_W-1:0]       pos;
        bit                                typed;
        drive_cmd_t                        cmd;
    } stim_row_t;

    typedef struct {
        bit         typed;
        drive_cmd_t cmd;
    } known_answer_t;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [lfpid_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lfpid_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [lfpid_pkg::S_DATA_W-1:0]    s_tdata;    // [12:0] line_position
    logic                              m_tvalid;
    logic                              m_tready;
    // [8:0] correction, [9] left_forward, [17:10] left_pwm,
    // [18] right_forward, [26:19] right_pwm
    logic [lfpid_pkg::M_DATA_W-1:0]    m_tdata;

    line_follow_pid_differential_drive_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of the registers and the loop state
    logic [7:0]        base_speed;
    logic [7:0]        turn_limit;
    logic signed [8:0] center_ref;
    logic [15:0]       kp, ki, kd;
    int                last_error;
    int                integ_sum;

    drive_cmd_t    expected_cmds[$];
    known_answer_t known_answers[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  positions_sent = 0;
    int  directed_sent = 0;
    int  reg_writes = 0;
    int  long_holds = 0;
    int  idle_cycles = 0;
    int  send_calm = 0;
    int  recv_calm = 0;
    bit  hold_req = 1'b0;
    bit  sender_rush = 1'b0;

    function automatic logic [8:0] motor_drive(int speed);
        int mag;
        mag = (speed < 0) ? -speed : speed;
        if (mag > PWM_FULL)
            mag = PWM_FULL;
        return {speed > 0, mag[7:0]};
    endfunction

    function automatic drive_cmd_t steer_from_position(logic [lfpid_pkg::POS_W-1:0] raw);
        int         pos, err, sum, lim, corr;
        longint     acc, c;
        drive_cmd_t cmd;
        pos = (raw > POSITION_SPAN) ? POSITION_SPAN : int'(raw);
        err = (pos * MAPPED_RANGE) / POSITION_SPAN - MAPPED_OFFSET - int'(center_ref);
        sum = integ_sum + err;
        if (sum > INTEG_HIGH)
            sum = INTEG_HIGH;
        if (sum < INTEG_LOW)
            sum = INTEG_LOW;
        integ_sum = sum;
        acc = longint'(err) * longint'(kp) + longint'(sum) * longint'(ki)
            + longint'(err - last_error) * longint'(kd);
        c = acc >>> 8;    // floor toward minus infinity
        lim = int'(turn_limit);
        if (c > lim)
            c = lim;
        if (c < -lim)
            c = -lim;
        corr = int'(c);
        last_error = err;
        cmd.correction = corr[8:0];
        {cmd.left_fwd, cmd.left_pwm} = motor_drive(int'(base_speed) + corr);
        {cmd.right_fwd, cmd.right_pwm} = motor_drive(int'(base_speed) - corr);
        return cmd;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // transfers on both streams; prediction happens at input acceptance
    always @(posedge aclk) begin
        drive_cmd_t    got, want;
        known_answer_t hint;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[26:0];
                results_seen++;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("correction", int'($signed(want.correction)),
                                int'($signed(got.correction)));
                    check_field("left_forward", want.left_fwd, got.left_fwd);
                    check_field("left_pwm", want.left_pwm, got.left_pwm);
                    check_field("right_forward", want.right_fwd, got.right_fwd);
                    check_field("right_pwm", want.right_pwm, got.right_pwm);
                end
            end
            if (s_tvalid && s_tready) begin
                want = steer_from_position(s_tdata[lfpid_pkg::POS_W-1:0]);
                hint = known_answers.pop_front();
                if (hint.typed)
                    want = hint.cmd;
                expected_cmds.push_back(want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
                long_holds++;
            end else begin
                gap = draw_gap(recv_calm);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_cmds.size());
        $display("[line_follow_pid_differential_drive_core] ERROR");
        $finish;
    end

    // called at a falling edge; leaves tvalid high so the next item can follow directly
    task automatic push_position(logic [lfpid_pkg::POS_W-1:0] pos, bit typed,
                                 drive_cmd_t cmd);
        int gap;
        gap = sender_rush ? 0 : draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        known_answers.push_back('{typed, cmd});
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lfpid_pkg::S_DATA_W-lfpid_pkg::POS_W){1'b0}}, pos};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        positions_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write enable stays high; the caller lowers it after the last write
    task automatic write_reg(logic [lfpid_pkg::CFG_INDEX_W-1:0] idx,
                             logic [lfpid_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            lfpid_pkg::REG_BASE_SPEED: base_speed = value[7:0];
            lfpid_pkg::REG_TURN_LIMIT: turn_limit = value[7:0];
            lfpid_pkg::REG_REFERENCE:  center_ref = value[8:0];
            lfpid_pkg::REG_GAIN_P:     kp = value;
            lfpid_pkg::REG_GAIN_I:     ki = value;
            lfpid_pkg::REG_GAIN_D:     kd = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
    endtask

    function automatic stim_row_t wr_row(logic [lfpid_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [lfpid_pkg::CFG_DATA_W-1:0] value);
        return '{ROW_WRITE, idx, value, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t pos_row(logic [lfpid_pkg::POS_W-1:0] pos);
        return '{ROW_ITEM, '0, '0, pos, 1'b0, '0};
    endfunction

    function automatic stim_row_t pos_row_exp(logic [lfpid_pkg::POS_W-1:0] pos, int corr,
                                              bit lf, int lp, bit rf, int rp);
        drive_cmd_t cmd;
        cmd.correction = 9'(corr);
        cmd.left_fwd   = lf;
        cmd.left_pwm   = 8'(lp);
        cmd.right_fwd  = rf;
        cmd.right_pwm  = 8'(rp);
        return '{ROW_ITEM, '0, '0, pos, 1'b1, cmd};
    endfunction

    function automatic logic [15:0] pick_level(int top);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'(top);
            2:       return 16'($urandom_range(0, top / 64));
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [lfpid_pkg::POS_W-1:0] draw_position(sweep_t sweep);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return 13'(POSITION_SPAN);
                default: return '1;
            endcase
        end
        case (sweep)
            SWEEP_HIGH:   return 13'($urandom_range(4000, POSITION_SPAN));
            SWEEP_LOW:    return 13'($urandom_range(0, 1000));
            SWEEP_CENTER: return 13'($urandom_range(2300, 2700));
            SWEEP_RAW:    return 13'($urandom_range(0, 8191));
            default:      return 13'($urandom_range(0, POSITION_SPAN));
        endcase
    endfunction

    initial begin
        stim_row_t         plan[$];
        bit                writing;
        int                phase;
        int                burst;
        int                random_sent;
        logic signed [8:0] ref_pick;
        sweep_t            sweep;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        base_speed = lfpid_pkg::BASE_SPEED_RST;
        turn_limit = lfpid_pkg::TURN_LIMIT_RST;
        center_ref = lfpid_pkg::REFERENCE_RST;
        kp = lfpid_pkg::GAIN_P_RST;
        ki = lfpid_pkg::GAIN_I_RST;
        kd = lfpid_pkg::GAIN_D_RST;
        last_error = 0;
        integ_sum  = 0;

        // reset settings: P only, clamp at 80, base 30
        plan.push_back(pos_row_exp(13'd0,    -80, 0, 50, 1, 110));
        plan.push_back(pos_row_exp(13'd5000,  80, 1, 110, 0, 50));
        plan.push_back(pos_row_exp(13'h1FFF,  80, 1, 110, 0, 50));   // clipped to full scale
        plan.push_back(pos_row_exp(13'd2500,   0, 1, 30, 1, 30));
        plan.push_back(pos_row_exp(13'd2795,  30, 1, 60, 0, 0));     // right motor stopped
        plan.push_back(wr_row(lfpid_pkg::REG_TURN_LIMIT, 16'd255));
        plan.push_back(wr_row(lfpid_pkg::REG_BASE_SPEED, 16'd255));
        plan.push_back(wr_row(UNUSED_LO, 16'hFFFF));
        plan.push_back(wr_row(UNUSED_HI, 16'hA5A5));
        plan.push_back(pos_row_exp(13'd5000, 255, 1, 255, 0, 0));
        plan.push_back(pos_row_exp(13'd0,   -255, 0, 0, 1, 255));
        plan.push_back(wr_row(lfpid_pkg::REG_BASE_SPEED, 16'd0));
        plan.push_back(wr_row(lfpid_pkg::REG_TURN_LIMIT, 16'd0));
        plan.push_back(pos_row_exp(13'd4000, 0, 0, 0, 0, 0));
        plan.push_back(wr_row(lfpid_pkg::REG_TURN_LIMIT, 16'd255));
        plan.push_back(wr_row(lfpid_pkg::REG_BASE_SPEED, 16'd128));
        plan.push_back(wr_row(lfpid_pkg::REG_REFERENCE, 16'hFF01));            // -255
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_P, 16'hFFFF));
        plan.push_back(pos_row_exp(13'd5000,  255, 1, 255, 0, 127));
        plan.push_back(wr_row(lfpid_pkg::REG_REFERENCE, 16'd255));
        plan.push_back(pos_row_exp(13'd0,    -255, 0, 127, 1, 255));
        // derivative only
        plan.push_back(wr_row(lfpid_pkg::REG_REFERENCE, 16'd0));
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_P, 16'd0));
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_D, 16'hFFFF));
        plan.push_back(pos_row(13'd5000));
        plan.push_back(pos_row(13'd0));
        plan.push_back(pos_row(13'd5000));
        plan.push_back(pos_row(13'd2500));
        // integral only, sum built up and then brought back to zero
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_D, 16'd0));
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_I, 16'hFFFF));
        plan.push_back(pos_row(13'd5000));
        plan.push_back(pos_row(13'd5000));
        plan.push_back(pos_row(13'd0));
        plan.push_back(pos_row(13'd1));
        // mixed mid-range settings
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_P, 16'd384));
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_I, 16'd3));
        plan.push_back(wr_row(lfpid_pkg::REG_GAIN_D, 16'd512));
        plan.push_back(wr_row(lfpid_pkg::REG_REFERENCE, 16'd17));
        plan.push_back(wr_row(lfpid_pkg::REG_TURN_LIMIT, 16'd200));
        plan.push_back(wr_row(lfpid_pkg::REG_BASE_SPEED, 16'd90));
        plan.push_back(pos_row(13'd1234));
        plan.push_back(pos_row(13'd3777));
        plan.push_back(pos_row(13'd4999));
        plan.push_back(pos_row(13'd1));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        writing = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!writing)
                    wait_idle();
                writing = 1'b1;
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                if (writing) begin
                    cfg_wr_en <= 1'b0;
                    writing = 1'b0;
                end
                push_position(plan[i].pos, plan[i].typed, plan[i].cmd);
                directed_sent++;
            end
        end

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            ref_pick = 9'($urandom_range(0, 2 * MAPPED_OFFSET) - MAPPED_OFFSET);
            case ($urandom_range(0, 4))
                0: ref_pick = -9'sd255;
                1: ref_pick = 9'sd255;
                default: ;
            endcase
            write_reg(lfpid_pkg::REG_BASE_SPEED, pick_level(PWM_FULL));
            write_reg(lfpid_pkg::REG_TURN_LIMIT, pick_level(PWM_FULL));
            write_reg(lfpid_pkg::REG_REFERENCE, {{7{ref_pick[8]}}, ref_pick});
            write_reg(lfpid_pkg::REG_GAIN_P, pick_level(65535));
            write_reg(lfpid_pkg::REG_GAIN_I, pick_level(65535));
            write_reg(lfpid_pkg::REG_GAIN_D, pick_level(65535));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? UNUSED_HI : UNUSED_LO, 16'($urandom()));
            cfg_wr_en <= 1'b0;

            sweep = sweep_t'($urandom_range(0, 4));
            burst = $urandom_range(20, 60);
            // second phase: back-to-back input against a long output hold-off
            if (phase == 1) begin
                sender_rush = 1'b1;
                hold_req = 1'b1;
            end
            repeat (burst)
                push_position(draw_position(sweep), 1'b0, '0);
            sender_rush = 1'b0;
            random_sent += burst;
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Covered %0d directed and %0d random positions over %0d phases, %0d results",
                 directed_sent, random_sent, phase, results_seen);
        $display("with %0d register writes and %0d long output stalls",
                 reg_writes, long_holds);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("[line_follow_pid_differential_drive_core] OK");
        else
            $display("[line_follow_pid_differential_drive_core] ERROR");
        $finish;
    end

endmodule
